// File: hw/rtl/mnrbs_pkg.sv
// ----------------------------------------------------------------------------
// mnrbs_pkg
// Types, codes and lookup functions for the MIDI note router / bank stepper.
// ----------------------------------------------------------------------------
package mnrbs_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_KEY_OFFSET   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_MEMORY = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_MODE   = 2'd2;

	localparam logic [1:0] KB_GREAT   = 2'd0;
	localparam logic [1:0] KB_SWELL   = 2'd1;
	localparam logic [1:0] KB_PEDAL   = 2'd2;
	localparam logic [1:0] KB_CONTROL = 2'd3;
	localparam logic [1:0] KB_NONE    = 2'd0;

	localparam logic [3:0] CONTROL_CHANNEL = 4'd9;

	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_PREV   = 2'd2;
	localparam logic [1:0] CMD_NEXT   = 2'd3;

	localparam logic       EV_NOTE = 1'b0;
	localparam logic       EV_BANK = 1'b1;

	localparam logic signed [4:0] OFFSET_MIN = -5'sd12;
	localparam logic signed [4:0] OFFSET_MAX = 5'sd12;

	localparam logic [7:0] LOW_KEY        = 8'd36;
	localparam logic [7:0] HIGH_KEY       = 8'd96;
	localparam logic [7:0] HIGH_PEDAL     = 8'd67;
	// top octave bases: key folds to 85..96, pedal to 56..67
	localparam logic [7:0] KEY_TOP_BASE   = 8'd84;
	localparam logic [7:0] PEDAL_BASE_HI  = 8'd48;
	localparam logic [7:0] PEDAL_BASE_LO  = 8'd60;
	localparam logic [3:0] PEDAL_REM_SPLIT = 4'd8;

	typedef struct packed {
		logic       load;
		logic [6:0] memory;
		logic [3:0] mode;
	} bank_load_t;

	typedef struct packed {
		logic [6:0] memory;
		logic [3:0] mode;
	} bank_state_t;

	function automatic logic [1:0] route_keyboard(input logic [3:0] channel);
		logic [1:0] kb;
		case (channel) inside
			4'd0, 4'd1, 4'd2, 4'd10, 4'd13: kb = KB_SWELL;
			4'd3, 4'd4, 4'd5, 4'd11, 4'd14: kb = KB_GREAT;
			4'd6, 4'd7, 4'd8, 4'd12, 4'd15: kb = KB_PEDAL;
			default:                        kb = KB_CONTROL;
		endcase
		return kb;
	endfunction

	function automatic logic [1:0] drum_command(input logic [6:0] key);
		logic [1:0] cmd;
		case (key) inside
			[7'd27:7'd30], [7'd32:7'd34], 7'd39, 7'd49, [7'd51:7'd53],
			[7'd55:7'd57], [7'd59:7'd61], 7'd70, [7'd73:7'd75],
			7'd78, 7'd79, [7'd85:7'd87]:
				cmd = CMD_NEXT;
			7'd31, [7'd35:7'd38], 7'd40, 7'd41, 7'd43, 7'd45, 7'd47, 7'd48,
			7'd50, 7'd54, 7'd65, 7'd66, 7'd71, 7'd72, [7'd80:7'd84]:
				cmd = CMD_PREV;
			7'd42, 7'd44, 7'd46, 7'd58, [7'd62:7'd64], [7'd67:7'd69],
			7'd76, 7'd77:
				cmd = CMD_CANCEL;
			default:
				cmd = CMD_NONE;
		endcase
		return cmd;
	endfunction

	// v mod 12 from v mod 4 and v mod 3 (base-4 digit sum)
	function automatic logic [3:0] mod12(input logic [7:0] v);
		logic [3:0] s;
		logic [3:0] s3;
		logic [2:0] d;
		logic [1:0] t;
		s  = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		s3 = (s >= 4'd9) ? s - 4'd9 : (s >= 4'd6) ? s - 4'd6 : (s >= 4'd3) ? s - 4'd3 : s;
		d  = 3'(s3[1:0]) + 3'd3 - 3'(v[1:0]);
		t  = (d >= 3'd3) ? 2'(d - 3'd3) : d[1:0];
		return {t, v[1:0]};
	endfunction

	function automatic logic [7:0] clamp_one(input logic [7:0] v, input logic [7:0] hi);
		logic [7:0] r;
		if (v < 8'd1) begin
			r = 8'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/mnrbs_note_if.sv
// ----------------------------------------------------------------------------
// mnrbs_note_if
// Valid/ready channel carrying one MIDI note event item.
// ----------------------------------------------------------------------------
interface mnrbs_note_if;
	logic       valid;
	logic       ready;
	logic [3:0] channel;
	logic [6:0] key_number;
	logic       is_on;

	modport source (output valid, output channel, output key_number, output is_on,
		input ready);
	modport sink (input valid, input channel, input key_number, input is_on,
		output ready);
endinterface

// File: hw/rtl/mnrbs_result_if.sv
// ----------------------------------------------------------------------------
// mnrbs_result_if
// Valid/ready channel carrying one routed note or bank change item.
// ----------------------------------------------------------------------------
interface mnrbs_result_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [1:0] keyboard;
	logic [6:0] mapped_key;
	logic       note_on;
	logic [6:0] bank_memory;
	logic [3:0] bank_mode;

	modport source (output valid, output event_kind, output keyboard, output mapped_key,
		output note_on, output bank_memory, output bank_mode, input ready);
	modport sink (input valid, input event_kind, input keyboard, input mapped_key,
		input note_on, input bank_memory, input bank_mode, output ready);
endinterface

// File: hw/rtl/mnrbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// mnrbs_cfg_regs
// Configuration registers with range clamping and bank load request.
// ----------------------------------------------------------------------------
module mnrbs_cfg_regs
	import mnrbs_pkg::*;
#(
	parameter int MAX_MEMORY       = 100,
	parameter int MODES_PER_MEMORY = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic signed [4:0]      key_offset,
	output bank_load_t             bank_load
);

	localparam logic [7:0] MAX_MEM_C  = 8'(MAX_MEMORY);
	localparam logic [7:0] MAX_MODE_C = 8'(MODES_PER_MEMORY);

	logic signed [4:0] key_offset_q;
	logic [6:0]        start_memory_q;
	logic [3:0]        start_mode_q;
	logic signed [4:0] offset_wr;
	logic [6:0]        mem_src;
	logic [3:0]        mode_src;
	logic [7:0]        mem_cl;
	logic [7:0]        mode_cl;

	always_comb begin
		offset_wr = $signed(cfg_data[4:0]);
		if (offset_wr < OFFSET_MIN) begin
			offset_wr = OFFSET_MIN;
		end else if (offset_wr > OFFSET_MAX) begin
			offset_wr = OFFSET_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_offset_q   <= '0;
			start_memory_q <= 7'd1;
			start_mode_q   <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_OFFSET:   key_offset_q   <= offset_wr;
				REG_START_MEMORY: start_memory_q <= cfg_data;
				REG_START_MODE:   start_mode_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mem_src  = (cfg_index == REG_START_MEMORY) ? cfg_data : start_memory_q;
		mode_src = (cfg_index == REG_START_MODE) ? cfg_data[3:0] : start_mode_q;
		mem_cl   = clamp_one({1'b0, mem_src}, MAX_MEM_C);
		mode_cl  = clamp_one({4'b0, mode_src}, MAX_MODE_C);
		bank_load.load   = cfg_we &&
			(cfg_index == REG_START_MEMORY || cfg_index == REG_START_MODE);
		bank_load.memory = mem_cl[6:0];
		bank_load.mode   = mode_cl[3:0];
	end

	assign key_offset = key_offset_q;

endmodule

// File: hw/rtl/mnrbs_key_fold.sv
// ----------------------------------------------------------------------------
// mnrbs_key_fold
// Transposes a key with 8-bit wrap and folds it by octaves into range.
// ----------------------------------------------------------------------------
module mnrbs_key_fold
	import mnrbs_pkg::*;
(
	input  logic [6:0]        key_number,
	input  logic signed [4:0] key_offset,
	input  logic              pedal,
	output logic [6:0]        mapped_key
);

	logic [7:0] shifted;
	logic [3:0] rem;
	logic [7:0] folded;

	always_comb begin
		shifted = {1'b0, key_number} + {{3{key_offset[4]}}, key_offset};
		rem     = mod12(shifted);
		if (shifted < LOW_KEY) begin
			folded = LOW_KEY + {4'b0, rem};
		end else if (pedal && shifted > HIGH_PEDAL) begin
			folded = (rem >= PEDAL_REM_SPLIT) ? PEDAL_BASE_HI + {4'b0, rem}
				: PEDAL_BASE_LO + {4'b0, rem};
		end else if (!pedal && shifted > HIGH_KEY) begin
			folded = (rem == 4'd0) ? HIGH_KEY : KEY_TOP_BASE + {4'b0, rem};
		end else begin
			folded = shifted;
		end
		mapped_key = folded[6:0];
	end

endmodule

// File: hw/rtl/mnrbs_bank.sv
// ----------------------------------------------------------------------------
// mnrbs_bank
// Combination bank state (memory, mode) and the drum command step.
// ----------------------------------------------------------------------------
module mnrbs_bank
	import mnrbs_pkg::*;
#(
	parameter int MAX_MEMORY       = 100,
	parameter int MODES_PER_MEMORY = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bank_load_t  bank_load,
	input  logic        step,
	input  logic [6:0]  key_number,
	output bank_state_t cur,
	output bank_state_t after
);

	localparam logic [7:0] MAX_MEM_C  = 8'(MAX_MEMORY);
	localparam logic [7:0] MAX_MODE_C = 8'(MODES_PER_MEMORY);

	logic [6:0] cur_memory_q;
	logic [3:0] cur_mode_q;
	logic [1:0] cmd;
	logic [7:0] mem_n;
	logic [7:0] mode_n;
	logic [7:0] mem_cl;
	logic [7:0] mode_cl;

	always_comb begin
		cmd    = drum_command(key_number);
		mem_n  = {1'b0, cur_memory_q};
		mode_n = {4'b0, cur_mode_q};
		case (cmd)
			CMD_CANCEL: mode_n = 8'd1;
			CMD_PREV: begin
				if (mode_n <= 8'd1) begin
					mode_n = MAX_MODE_C;
					mem_n  = (mem_n == 8'd0) ? 8'd0 : mem_n - 8'd1;
				end else begin
					mode_n = mode_n - 8'd1;
				end
			end
			CMD_NEXT: begin
				mode_n = mode_n + 8'd1;
				if (mode_n >= MAX_MODE_C) begin
					mode_n = 8'd1;
					mem_n  = mem_n + 8'd1;
				end
			end
			default: ;
		endcase
		mem_cl       = clamp_one(mem_n, MAX_MEM_C);
		mode_cl      = clamp_one(mode_n, MAX_MODE_C);
		after.memory = mem_cl[6:0];
		after.mode   = mode_cl[3:0];
		cur.memory   = cur_memory_q;
		cur.mode     = cur_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_memory_q <= 7'd1;
			cur_mode_q   <= 4'd1;
		end else if (bank_load.load) begin
			cur_memory_q <= bank_load.memory;
			cur_mode_q   <= bank_load.mode;
		end else if (step) begin
			cur_memory_q <= after.memory;
			cur_mode_q   <= after.mode;
		end
	end

endmodule

// File: hw/rtl/midi_note_router_bank_stepper.sv
// ----------------------------------------------------------------------------
// midi_note_router_bank_stepper
// Routes MIDI note items to keyboards with transposition and octave folding;
// control-channel note-ons step the combination bank and report its state.
//
//   channel     dir  payload                                            items
//   note_in     in   channel, key_number, is_on                         1/cycle
//   result_out  out  event_kind, keyboard, mapped_key, note_on,         0..1 per
//                    bank_memory, bank_mode                             item
//   cfg         in   cfg_we, cfg_index, cfg_data                        -
//
// One item per cycle sustained while result_out is not back-pressured; items pass the input
// register, then the result register. The bank step and key fold sit between the two.
// A control note-off is dropped at the result register.
// arst_n clears valids, config registers and bank state (memory 1, mode 1).
// Back-pressure on result_out stalls the result register and then the input.
// ----------------------------------------------------------------------------
module midi_note_router_bank_stepper
	import mnrbs_pkg::*;
#(
	parameter int MAX_MEMORY       = 100,
	parameter int MODES_PER_MEMORY = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	mnrbs_note_if.sink             note_in,
	mnrbs_result_if.source         result_out,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic              valid_s1;
	logic [3:0]        channel_s1;
	logic [6:0]        key_s1;
	logic              on_s1;
	logic              valid_s2;
	logic              kind_s2;
	logic [1:0]        kb_s2;
	logic [6:0]        mapped_s2;
	logic              on_s2;
	logic [6:0]        memory_s2;
	logic [3:0]        mode_s2;

	logic              adv_s1;
	logic              is_ctrl;
	logic              emit;
	logic              step;
	logic [1:0]        kb;
	logic [6:0]        mapped_key;
	logic signed [4:0] key_offset;
	bank_load_t        bank_load;
	bank_state_t       bank_cur;
	bank_state_t       bank_after;

	mnrbs_cfg_regs #(
		.MAX_MEMORY       (MAX_MEMORY),
		.MODES_PER_MEMORY (MODES_PER_MEMORY)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.key_offset (key_offset),
		.bank_load  (bank_load)
	);

	mnrbs_key_fold u_fold (
		.key_number (key_s1),
		.key_offset (key_offset),
		.pedal      (kb == KB_PEDAL),
		.mapped_key (mapped_key)
	);

	mnrbs_bank #(
		.MAX_MEMORY       (MAX_MEMORY),
		.MODES_PER_MEMORY (MODES_PER_MEMORY)
	) u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.bank_load  (bank_load),
		.step       (step),
		.key_number (key_s1),
		.cur        (bank_cur),
		.after      (bank_after)
	);

	assign adv_s1        = !valid_s2 || result_out.ready;
	assign note_in.ready = !valid_s1 || adv_s1;
	assign kb            = route_keyboard(channel_s1);
	assign is_ctrl       = (channel_s1 == CONTROL_CHANNEL);
	assign emit          = valid_s1 && !(is_ctrl && !on_s1);
	assign step          = valid_s1 && adv_s1 && is_ctrl && on_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (note_in.ready) begin
			valid_s1 <= note_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (note_in.ready && note_in.valid) begin
			channel_s1 <= note_in.channel;
			key_s1     <= note_in.key_number;
			on_s1      <= note_in.is_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			if (is_ctrl) begin
				kind_s2   <= EV_BANK;
				kb_s2     <= KB_NONE;
				mapped_s2 <= '0;
				on_s2     <= 1'b1;
				memory_s2 <= bank_after.memory;
				mode_s2   <= bank_after.mode;
			end else begin
				kind_s2   <= EV_NOTE;
				kb_s2     <= kb;
				mapped_s2 <= mapped_key;
				on_s2     <= on_s1;
				memory_s2 <= bank_cur.memory;
				mode_s2   <= bank_cur.mode;
			end
		end
	end

	assign result_out.valid       = valid_s2;
	assign result_out.event_kind  = kind_s2;
	assign result_out.keyboard    = kb_s2;
	assign result_out.mapped_key  = mapped_s2;
	assign result_out.note_on     = on_s2;
	assign result_out.bank_memory = memory_s2;
	assign result_out.bank_mode   = mode_s2;

endmodule

// File: hw/rtl/mnrbs_checker.sv
// ----------------------------------------------------------------------------
// mnrbs_checker
// Port-level checks on the result channel of the note router.
// ----------------------------------------------------------------------------
module mnrbs_checker
	import mnrbs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       event_kind,
	input logic [1:0] keyboard,
	input logic [6:0] mapped_key,
	input logic       note_on,
	input logic [6:0] bank_memory,
	input logic [3:0] bank_mode
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mapped_key) && $stable(bank_mode))
		else $error("result item changed while stalled");

	a_note_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_NOTE |->
			keyboard != KB_CONTROL && mapped_key >= 7'd36 && mapped_key <= 7'd96)
		else $error("note item out of range");

	a_pedal_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_NOTE && keyboard == KB_PEDAL |-> mapped_key <= 7'd67)
		else $error("pedal key above pedal range");

	a_bank_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_BANK |->
			keyboard == KB_NONE && mapped_key == 7'd0 && note_on)
		else $error("bank item carries note fields");

	a_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bank_memory != 7'd0 && bank_mode != 4'd0)
		else $error("bank state below one");

endmodule

bind midi_note_router_bank_stepper mnrbs_checker u_mnrbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.event_kind  (result_out.event_kind),
	.keyboard    (result_out.keyboard),
	.mapped_key  (result_out.mapped_key),
	.note_on     (result_out.note_on),
	.bank_memory (result_out.bank_memory),
	.bank_mode   (result_out.bank_mode)
);

// File: sim/midi_note_router_bank_stepper_tb.sv
// ----------------------------------------------------------------------------
// midi_note_router_bank_stepper_tb
// Self-checking bench for the MIDI note router / bank stepper. Note items go
// through a bursty driver. The receiver stalls in a pattern of its own. A
// predictor of keyboard routing, transposition, octave folding and bank
// stepping checks each result item in order. Register settings change between
// phases, while the block is idle.
// ----------------------------------------------------------------------------
module midi_note_router_bank_stepper_tb;
	import mnrbs_pkg::*;

	localparam int MAX_MEMORY       = 100;
	localparam int MODES_PER_MEMORY = 8;
	localparam int OCTAVE           = 12;
	localparam int SETTLE_CYCLES    = 4;
	localparam int IDLE_LIMIT       = 2000;
	localparam int RANDOM_PHASES    = 8;
	localparam int PHASE_ITEMS      = 125;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	// drum commands for keys 27..87: n next, p previous, c cancel
	localparam int DRUM_FIRST = 27;
	localparam int DRUM_LAST  = 87;
	localparam logic [8*61-1:0] DRUM_CODES =
		{"nnnnpnnnpp", "ppnppcpcpc", "ppnpnnnpnn", "ncnnncccpp", "cccnppnnnc",
		"cnnpppppnn", "n"};

	typedef struct packed {
		logic [3:0] channel;
		logic [6:0] key_number;
		logic       is_on;
	} note_t;

	typedef struct packed {
		logic       event_kind;
		logic [1:0] keyboard;
		logic [6:0] mapped_key;
		logic       note_on;
		logic [6:0] bank_memory;
		logic [3:0] bank_mode;
	} routed_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	mnrbs_note_if   note_bus ();
	mnrbs_result_if result_bus ();

	midi_note_router_bank_stepper #(
		.MAX_MEMORY       (MAX_MEMORY),
		.MODES_PER_MEMORY (MODES_PER_MEMORY)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.note_in    (note_bus),
		.result_out (result_bus),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	note_t   note_q[$];
	routed_t routed_q[$];
	int      notes_queued;
	int      notes_accepted;
	int      fail_cnt;
	int      idle_cycles;

	int      transpose;
	int      start_mem;
	int      start_md;
	int      bank_mem;
	int      bank_md;

	int          burst_left;
	int          gap_left;
	logic [15:0] stall_pat;
	int          pat_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic logic [1:0] keyboard_of(input logic [3:0] ch);
		logic [1:0] kb;
		case (ch)
			4'd0, 4'd1, 4'd2, 4'd10, 4'd13: kb = KB_SWELL;
			4'd3, 4'd4, 4'd5, 4'd11, 4'd14: kb = KB_GREAT;
			4'd6, 4'd7, 4'd8, 4'd12, 4'd15: kb = KB_PEDAL;
			default:                        kb = KB_CONTROL;
		endcase
		return kb;
	endfunction

	function automatic logic [1:0] drum_cmd_of(input logic [6:0] key);
		logic [7:0] code;
		int         k;
		k = int'(key);
		if (k < DRUM_FIRST || k > DRUM_LAST) begin
			return CMD_NONE;
		end
		code = DRUM_CODES[8*(DRUM_LAST-k) +: 8];
		case (code)
			"n":     return CMD_NEXT;
			"p":     return CMD_PREV;
			"c":     return CMD_CANCEL;
			default: return CMD_NONE;
		endcase
	endfunction

	function automatic logic [6:0] fold_key(input logic [6:0] key, input logic [1:0] kb);
		int k;
		int hi;
		hi = (kb == KB_PEDAL) ? int'(HIGH_PEDAL) : int'(HIGH_KEY);
		k = (int'(key) + 256 + transpose) & 255;
		while (k < int'(LOW_KEY)) k += OCTAVE;
		while (k > hi) k -= OCTAVE;
		return 7'(k);
	endfunction

	function automatic void load_bank();
		bank_mem = clamp_int(start_mem, 1, MAX_MEMORY);
		bank_md  = clamp_int(start_md, 1, MODES_PER_MEMORY);
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		logic signed [4:0] off;
		off = data[4:0];
		case (idx)
			REG_KEY_OFFSET: begin
				transpose = clamp_int(int'(off), int'(OFFSET_MIN), int'(OFFSET_MAX));
			end
			REG_START_MEMORY: begin
				start_mem = int'(data);
				load_bank();
			end
			REG_START_MODE: begin
				start_md = int'(data[3:0]);
				load_bank();
			end
			default: begin
			end
		endcase
	endfunction

	// returns 1 when the note item yields a result item
	function automatic bit route_note(input note_t n, output routed_t r);
		logic [1:0] kb;
		logic [1:0] cmd;
		int         mem;
		int         md;
		kb = keyboard_of(n.channel);
		r = '0;
		if (n.channel == CONTROL_CHANNEL) begin
			if (!n.is_on) begin
				return 1'b0;
			end
			cmd = drum_cmd_of(n.key_number);
			mem = bank_mem;
			md  = bank_md;
			case (cmd)
				CMD_CANCEL: md = 1;
				CMD_PREV: begin
					if (md <= 1) begin
						md  = MODES_PER_MEMORY;
						mem = (mem == 0) ? 0 : mem - 1;
					end else begin
						md -= 1;
					end
				end
				CMD_NEXT: begin
					md += 1;
					if (md >= MODES_PER_MEMORY) begin
						md = 1;
						mem += 1;
					end
				end
				default: begin
				end
			endcase
			bank_mem = clamp_int(mem, 1, MAX_MEMORY);
			bank_md  = clamp_int(md, 1, MODES_PER_MEMORY);
			r.event_kind = EV_BANK;
			r.keyboard   = KB_NONE;
			r.mapped_key = '0;
			r.note_on    = 1'b1;
		end else begin
			r.event_kind = EV_NOTE;
			r.keyboard   = kb;
			r.mapped_key = fold_key(n.key_number, kb);
			r.note_on    = n.is_on;
		end
		r.bank_memory = 7'(bank_mem);
		r.bank_mode   = 4'(bank_md);
		return 1'b1;
	endfunction

	function automatic note_t random_note();
		note_t n;
		int    sel;
		sel = $urandom_range(0, 99);
		n.channel    = 4'($urandom_range(0, 15));
		n.key_number = 7'($urandom);
		n.is_on      = 1'($urandom);
		if (sel < 35) begin
			n.channel = CONTROL_CHANNEL;
			if (sel < 28) begin
				n.key_number = 7'($urandom_range(DRUM_FIRST, DRUM_LAST));
				n.is_on      = 1'b1;
			end
		end
		return n;
	endfunction

	task automatic queue_note(input logic [3:0] ch, input logic [6:0] key, input logic on);
		note_q.insert(note_q.size(), note_t'{channel: ch, key_number: key, is_on: on});
		notes_queued++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		apply_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain(input int settle);
		do @(posedge clk);
		while (notes_accepted != notes_queued || routed_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		note_t   n;
		routed_t r;
		if (arst_n) begin
			if (note_bus.valid && note_bus.ready) begin
				n.channel    = note_bus.channel;
				n.key_number = note_bus.key_number;
				n.is_on      = note_bus.is_on;
				if (route_note(n, r)) begin
					routed_q.insert(routed_q.size(), r);
				end
				notes_accepted++;
			end
			if (!note_bus.valid || note_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					note_bus.valid <= 1'b0;
				end else if (note_q.size() > 0) begin
					n = note_q.pop_front();
					note_bus.channel    <= n.channel;
					note_bus.key_number <= n.key_number;
					note_bus.is_on      <= n.is_on;
					note_bus.valid      <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					note_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		routed_t r;
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				if (routed_q.size() == 0) begin
					$error("unexpected result item");
					fail_cnt++;
				end else begin
					r = routed_q.pop_front();
					check_field("event_kind", r.event_kind, result_bus.event_kind);
					check_field("keyboard", r.keyboard, result_bus.keyboard);
					check_field("mapped_key", r.mapped_key, result_bus.mapped_key);
					check_field("note_on", r.note_on, result_bus.note_on);
					check_field("bank_memory", r.bank_memory, result_bus.bank_memory);
					check_field("bank_mode", r.bank_mode, result_bus.bank_mode);
				end
			end
			if ((result_bus.valid && result_bus.ready) || (note_bus.valid && note_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (pat_left == 0) begin
				pat_left = $urandom_range(16, 96);
				case ($urandom_range(0, 2))
					0:       stall_pat = '1;
					1:       stall_pat = 16'($urandom) | 16'h0001;
					default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
				endcase
			end else begin
				pat_left--;
				stall_pat = {stall_pat[0], stall_pat[15:1]};
			end
			result_bus.ready <= stall_pat[0];
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0] mem_data;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_KEY_OFFSET;
		cfg_data            = '0;
		note_bus.valid      = 1'b0;
		note_bus.channel    = '0;
		note_bus.key_number = '0;
		note_bus.is_on      = 1'b0;
		result_bus.ready    = 1'b0;
		notes_queued   = 0;
		notes_accepted = 0;
		fail_cnt       = 0;
		idle_cycles    = 0;
		burst_left     = 1;
		gap_left       = 0;
		stall_pat      = '1;
		pat_left       = 0;
		transpose      = 0;
		start_mem      = 1;
		start_md       = 1;
		load_bank();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: fold edges, every keyboard, each drum command
		queue_note(4'd0, 7'd0, 1'b1);
		queue_note(4'd1, 7'd127, 1'b0);
		queue_note(4'd3, 7'd127, 1'b1);
		queue_note(4'd4, 7'd36, 1'b1);
		queue_note(4'd6, 7'd127, 1'b1);
		queue_note(4'd15, 7'd0, 1'b0);
		queue_note(CONTROL_CHANNEL, 7'd31, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd27, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd42, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd0, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd27, 1'b0);
		queue_note(CONTROL_CHANNEL, 7'd127, 1'b1);
		drain(SETTLE_CYCLES);

		// lowest offset with wrap below zero, memory at the top
		write_reg(REG_KEY_OFFSET, 7'h74);
		write_reg(REG_START_MEMORY, 7'd100);
		write_reg(REG_START_MODE, 7'd7);
		queue_note(4'd5, 7'd0, 1'b1);
		queue_note(4'd12, 7'd127, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd27, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd35, 1'b1);
		drain(SETTLE_CYCLES);

		// offset above range, bank load values out of range
		write_reg(REG_KEY_OFFSET, 7'h0F);
		write_reg(REG_START_MEMORY, 7'd0);
		write_reg(REG_START_MODE, 7'h7F);
		queue_note(4'd2, 7'd127, 1'b1);
		queue_note(4'd8, 7'd120, 1'b0);
		queue_note(CONTROL_CHANNEL, 7'd27, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd31, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd31, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd27, 1'b1);
		drain(SETTLE_CYCLES);

		// offset below range, unused register index
		write_reg(REG_KEY_OFFSET, 7'h10);
		write_reg(REG_UNUSED, 7'h55);
		queue_note(4'd7, 7'd0, 1'b1);
		queue_note(4'd10, 7'd50, 1'b1);
		queue_note(CONTROL_CHANNEL, 7'd44, 1'b1);
		drain(SETTLE_CYCLES);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(REG_KEY_OFFSET, 7'($urandom));
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 3))
					0:       mem_data = 7'($urandom_range(0, 5));
					1:       mem_data = 7'($urandom_range(95, 127));
					default: mem_data = 7'($urandom);
				endcase
				write_reg(REG_START_MEMORY, mem_data);
				write_reg(REG_START_MODE, 7'($urandom));
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, 7'($urandom));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				note_q.insert(note_q.size(), random_note());
				notes_queued++;
			end
			drain(SETTLE_CYCLES);
		end

		drain(2 * SETTLE_CYCLES);
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: midi_note_router_bank_stepper.f
hw/rtl/mnrbs_pkg.sv
hw/rtl/mnrbs_note_if.sv
hw/rtl/mnrbs_result_if.sv
hw/rtl/mnrbs_cfg_regs.sv
hw/rtl/mnrbs_key_fold.sv
hw/rtl/mnrbs_bank.sv
hw/rtl/midi_note_router_bank_stepper.sv
hw/rtl/mnrbs_checker.sv
sim/midi_note_router_bank_stepper_tb.sv
